// ----- rtl/core/sfcc_pkg.sv -----
`default_nettype none

package sfcc_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] word_type;

   // Result item kinds.
   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_REPORT = 1'b1
   } kind_type;

   // A ones' complement partial sum together with its pending end-around carry.
   typedef struct packed {
      logic     carry;
      word_type sum;
   } acc_type;

   localparam byte_type    FLAG_BYTE       = 8'h7E;
   localparam byte_type    ESC_BYTE        = 8'h7D;
   localparam word_type    ALL_ONES        = 16'hFFFF;
   localparam int unsigned MIN_FRAME_BYTES = 6;
   localparam int unsigned HOLD_DEPTH      = 2;

   // Adds one word and the carry held from the previous add.
   function automatic acc_type ones_add(input acc_type acc, input word_type word);
      logic [16:0] total;
      total = {1'b0, acc.sum} + {1'b0, word} + 17'(acc.carry);
      return acc_type'(total);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sfcc_req_if.sv -----
`default_nettype none

interface sfcc_req_if;
   logic               valid;
   logic               ready;
   sfcc_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sfcc_rsp_if.sv -----
`default_nettype none

interface sfcc_rsp_if;
   logic               valid;
   logic               ready;
   sfcc_pkg::kind_type kind;
   sfcc_pkg::byte_type data_byte;
   sfcc_pkg::byte_type address;
   sfcc_pkg::byte_type control_field;
   sfcc_pkg::word_type protocol;
   sfcc_pkg::word_type checksum_word;
   logic               checksum_ok;
   logic               too_short;
   sfcc_pkg::word_type frame_bytes;

   modport source (
      output valid, output kind, output data_byte, output address, output control_field,
      output protocol, output checksum_word, output checksum_ok, output too_short,
      output frame_bytes, input ready
   );
   modport sink (
      input valid, input kind, input data_byte, input address, input control_field,
      input protocol, input checksum_word, input checksum_ok, input too_short,
      input frame_bytes, output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/stuffed_frame_checksum_checker.sv -----
// A transferred byte is loaded into the input register, and the result that it causes then into
// the result register. Throughput: one byte per cycle while the result register is not stalled,
// set by the checksum update on the input register. A stalled result register holds its item
// while the input register still takes one more byte. Reset is synchronous and active high; it
// clears all frame state as if a flag had just been seen and drops any byte or result in flight.
`default_nettype none

module stuffed_frame_checksum_checker #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   sfcc_req_if.sink    req_chan,
   sfcc_rsp_if.source  rsp_chan
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_HOLD  = COUNT_WIDTH'(sfcc_pkg::HOLD_DEPTH);
   localparam logic [COUNT_WIDTH-1:0] COUNT_SHORT = COUNT_WIDTH'(sfcc_pkg::MIN_FRAME_BYTES);

   // Input register.
   logic               s1_valid_ff, s1_valid_in;
   sfcc_pkg::byte_type s1_byte_ff;

   // Frame state.
   logic                                 in_frame_ff, in_frame_in;
   logic                                 prev_esc_ff, prev_esc_in;
   logic [COUNT_WIDTH-1:0]               count_ff, count_in;
   logic [1:0][7:0]                      hold_byte_ff, hold_byte_in;
   logic [1:0]                           hold_drop_ff, hold_drop_in;
   sfcc_pkg::acc_type                    acc_ff, acc_in;
   logic                                 pend_valid_ff, pend_valid_in;
   sfcc_pkg::byte_type                   pend_byte_ff, pend_byte_in;
   sfcc_pkg::byte_type                   addr_ff, addr_in;
   sfcc_pkg::byte_type                   ctrl_ff, ctrl_in;
   sfcc_pkg::word_type                   proto_ff, proto_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   sfcc_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   sfcc_pkg::byte_type rsp_data_ff, rsp_data_in;
   sfcc_pkg::byte_type rsp_addr_ff, rsp_addr_in;
   sfcc_pkg::byte_type rsp_ctrl_ff, rsp_ctrl_in;
   sfcc_pkg::word_type rsp_proto_ff, rsp_proto_in;
   sfcc_pkg::word_type rsp_ck_ff, rsp_ck_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic               rsp_short_ff, rsp_short_in;
   sfcc_pkg::word_type rsp_fbytes_ff, rsp_fbytes_in;

   logic               out_free;
   logic               advance;
   logic               produce;
   logic               is_flag;
   sfcc_pkg::word_type ck_word;
   sfcc_pkg::acc_type  acc_pad;
   sfcc_pkg::acc_type  acc_ck;
   sfcc_pkg::word_type final_sum;
   logic [31:0]        count_wide;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign s1_valid_in    = req_chan.ready ? req_chan.valid : s1_valid_ff;

   assign is_flag    = (s1_byte_ff == sfcc_pkg::FLAG_BYTE) && !prev_esc_ff;
   assign ck_word    = {hold_byte_ff[0], hold_byte_ff[1]};
   assign count_wide = 32'(count_ff);

   // Closing sum: the padded odd byte, then the checksum word, then the last carry.
   assign acc_pad   = pend_valid_ff ? sfcc_pkg::ones_add(acc_ff, {pend_byte_ff, 8'h00}) : acc_ff;
   assign acc_ck    = sfcc_pkg::ones_add(acc_pad, ck_word);
   assign final_sum = acc_ck.sum + 16'(acc_ck.carry);

   always_comb begin
      in_frame_in   = in_frame_ff;
      prev_esc_in   = prev_esc_ff;
      count_in      = count_ff;
      hold_byte_in  = hold_byte_ff;
      hold_drop_in  = hold_drop_ff;
      acc_in        = acc_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      addr_in       = addr_ff;
      ctrl_in       = ctrl_ff;
      proto_in      = proto_ff;

      produce       = 1'b0;
      rsp_kind_in   = sfcc_pkg::KIND_DATA;
      rsp_data_in   = '0;
      rsp_addr_in   = '0;
      rsp_ctrl_in   = '0;
      rsp_proto_in  = '0;
      rsp_ck_in     = '0;
      rsp_ok_in     = 1'b0;
      rsp_short_in  = 1'b0;
      rsp_fbytes_in = '0;

      if (advance) begin
         prev_esc_in = (s1_byte_ff == sfcc_pkg::ESC_BYTE);
         if (is_flag) begin
            if (in_frame_ff) begin
               produce       = 1'b1;
               rsp_kind_in   = sfcc_pkg::KIND_REPORT;
               rsp_addr_in   = addr_ff;
               rsp_ctrl_in   = ctrl_ff;
               rsp_proto_in  = proto_ff;
               rsp_ck_in     = ck_word;
               rsp_ok_in     = (final_sum == sfcc_pkg::ALL_ONES);
               rsp_short_in  = (count_ff < COUNT_SHORT);
               rsp_fbytes_in = (count_wide > 32'(sfcc_pkg::ALL_ONES)) ?
                               sfcc_pkg::ALL_ONES : count_wide[15:0];
            end
            in_frame_in   = 1'b0;
            count_in      = '0;
            hold_byte_in  = '0;
            hold_drop_in  = '0;
            acc_in        = '0;
            pend_valid_in = 1'b0;
            pend_byte_in  = '0;
            addr_in       = '0;
            ctrl_in       = '0;
            proto_in      = '0;
         end else begin
            in_frame_in = 1'b1;
            // The older held byte leaves the holdback once two bytes are in it.
            if (count_ff >= COUNT_HOLD) begin
               if (pend_valid_ff) begin
                  acc_in        = sfcc_pkg::ones_add(acc_ff, {pend_byte_ff, hold_byte_ff[0]});
                  pend_valid_in = 1'b0;
                  pend_byte_in  = '0;
               end else begin
                  pend_valid_in = 1'b1;
                  pend_byte_in  = hold_byte_ff[0];
               end
               if (count_ff >= COUNT_SHORT && !hold_drop_ff[0]) begin
                  produce     = 1'b1;
                  rsp_data_in = hold_byte_ff[0];
               end
            end
            case (count_ff)
               COUNT_WIDTH'(0): addr_in        = s1_byte_ff;
               COUNT_WIDTH'(1): ctrl_in        = s1_byte_ff;
               COUNT_WIDTH'(2): proto_in[15:8] = s1_byte_ff;
               COUNT_WIDTH'(3): proto_in[7:0]  = s1_byte_ff;
               default: ;
            endcase
            hold_byte_in[0] = hold_byte_ff[1];
            hold_drop_in[0] = hold_drop_ff[1];
            hold_byte_in[1] = s1_byte_ff;
            hold_drop_in[1] = (s1_byte_ff == sfcc_pkg::ESC_BYTE) && !prev_esc_ff;
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end
      end

      rsp_valid_in = out_free ? produce : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         in_frame_ff   <= 1'b0;
         prev_esc_ff   <= 1'b0;
         count_ff      <= '0;
         hold_byte_ff  <= '0;
         hold_drop_ff  <= '0;
         acc_ff        <= '0;
         pend_valid_ff <= 1'b0;
         pend_byte_ff  <= '0;
         addr_ff       <= '0;
         ctrl_ff       <= '0;
         proto_ff      <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         in_frame_ff   <= in_frame_in;
         prev_esc_ff   <= prev_esc_in;
         count_ff      <= count_in;
         hold_byte_ff  <= hold_byte_in;
         hold_drop_ff  <= hold_drop_in;
         acc_ff        <= acc_in;
         pend_valid_ff <= pend_valid_in;
         pend_byte_ff  <= pend_byte_in;
         addr_ff       <= addr_in;
         ctrl_ff       <= ctrl_in;
         proto_ff      <= proto_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_byte_ff <= req_chan.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && produce) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_ctrl_ff   <= rsp_ctrl_in;
         rsp_proto_ff  <= rsp_proto_in;
         rsp_ck_ff     <= rsp_ck_in;
         rsp_ok_ff     <= rsp_ok_in;
         rsp_short_ff  <= rsp_short_in;
         rsp_fbytes_ff <= rsp_fbytes_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.data_byte     = rsp_data_ff;
   assign rsp_chan.address       = rsp_addr_ff;
   assign rsp_chan.control_field = rsp_ctrl_ff;
   assign rsp_chan.protocol      = rsp_proto_ff;
   assign rsp_chan.checksum_word = rsp_ck_ff;
   assign rsp_chan.checksum_ok   = rsp_ok_ff;
   assign rsp_chan.too_short     = rsp_short_ff;
   assign rsp_chan.frame_bytes   = rsp_fbytes_ff;

`ifndef ASSERT_OFF
   // Every byte counted belongs to an open frame, and an open frame has counted a byte.
   a_frame_count: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff == (count_ff != '0))
      else $error("frame flag and byte count disagree");

   // Only an unescaped escape byte may be marked for dropping in the holdback.
   a_drop_mark: assert property (@(posedge clock) disable iff (reset)
      (hold_drop_ff[0] |-> hold_byte_ff[0] == sfcc_pkg::ESC_BYTE) and
      (hold_drop_ff[1] |-> hold_byte_ff[1] == sfcc_pkg::ESC_BYTE))
      else $error("drop mark on a byte that is not an escape");

   // A frame report flags a short frame exactly when its byte count is below the minimum.
   a_short_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == sfcc_pkg::KIND_REPORT) |->
      (rsp_short_ff == (rsp_fbytes_ff < 16'(sfcc_pkg::MIN_FRAME_BYTES))))
      else $error("short-frame flag does not match the frame length");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_stuffed_frame_checksum_checker.sv -----
`timescale 1ns / 1ps

module tb_stuffed_frame_checksum_checker;

   localparam int COUNT_BITS      = 16;
   localparam int PRESSURE_CYCLES = 150;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int RANDOM_BYTES    = 1550;
   localparam int LONG_FRAME      = 320;

   typedef struct packed {
      sfcc_pkg::kind_type kind;
      sfcc_pkg::byte_type data_byte;
      sfcc_pkg::byte_type address;
      sfcc_pkg::byte_type control_field;
      sfcc_pkg::word_type protocol;
      sfcc_pkg::word_type checksum_word;
      logic               checksum_ok;
      logic               too_short;
      sfcc_pkg::word_type frame_bytes;
   } frame_rsp_type;

   localparam frame_rsp_type NO_RSP = '0;

   typedef struct {
      sfcc_pkg::byte_type rx;
      bit                 typed;
      bit                 yields;
      frame_rsp_type      rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sfcc_req_if req_bus ();
   sfcc_rsp_if rsp_bus ();

   stuffed_frame_checksum_checker #(.COUNT_WIDTH(COUNT_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Deframer state as the block should hold it.
   bit                    m_in_frame;
   bit                    m_prev_esc;
   logic [COUNT_BITS-1:0] m_count;
   sfcc_pkg::byte_type    m_hold [2];
   bit                    m_hold_drop [2];
   sfcc_pkg::word_type    m_sum;
   bit                    m_carry;
   logic [8:0]            m_pend;
   sfcc_pkg::byte_type    m_addr;
   sfcc_pkg::byte_type    m_ctrl;
   sfcc_pkg::word_type    m_proto;

   frame_rsp_type expected_rsps [$];
   int            fail_count;
   int            bytes_sent;
   bit            tail_phase;
   bit            sender_calm;
   int            quiet_cycles;

   function automatic frame_rsp_type data_rsp(input sfcc_pkg::byte_type d);
      frame_rsp_type r;
      r = NO_RSP;
      r.kind = sfcc_pkg::KIND_DATA;
      r.data_byte = d;
      return r;
   endfunction

   function automatic frame_rsp_type report_rsp(input sfcc_pkg::byte_type a,
                                                input sfcc_pkg::byte_type c,
                                                input sfcc_pkg::word_type p,
                                                input sfcc_pkg::word_type ck,
                                                input logic ok, input logic short_frame,
                                                input sfcc_pkg::word_type len);
      frame_rsp_type r;
      r = NO_RSP;
      r.kind = sfcc_pkg::KIND_REPORT;
      r.address = a;
      r.control_field = c;
      r.protocol = p;
      r.checksum_word = ck;
      r.checksum_ok = ok;
      r.too_short = short_frame;
      r.frame_bytes = len;
      return r;
   endfunction

   function automatic void acc_word(input sfcc_pkg::word_type w);
      logic [16:0] t;
      t = {1'b0, m_sum} + {1'b0, w} + 17'(m_carry);
      m_sum = t[15:0];
      m_carry = t[16];
   endfunction

   function automatic void clear_frame_state();
      m_in_frame = 1'b0;
      m_count = '0;
      m_hold[0] = '0;
      m_hold[1] = '0;
      m_hold_drop[0] = 1'b0;
      m_hold_drop[1] = 1'b0;
      m_sum = '0;
      m_carry = 1'b0;
      m_pend = '0;
      m_addr = '0;
      m_ctrl = '0;
      m_proto = '0;
   endfunction

   // Advances the deframer by one raw byte; returns 1 when the byte yields a result.
   function automatic bit deframe_byte(input sfcc_pkg::byte_type b, output frame_rsp_type r);
      bit                 esc_before;
      bit                 yields;
      sfcc_pkg::byte_type oldest;
      sfcc_pkg::word_type ck;
      sfcc_pkg::word_type folded;
      sfcc_pkg::word_type len;
      esc_before = m_prev_esc;
      yields = 1'b0;
      r = NO_RSP;
      m_prev_esc = (b == sfcc_pkg::ESC_BYTE);
      if (b == sfcc_pkg::FLAG_BYTE && !esc_before) begin
         if (m_in_frame) begin
            ck = {m_hold[0], m_hold[1]};
            if (m_pend[8])
               acc_word({m_pend[7:0], 8'h00});
            acc_word(ck);
            // The last carry goes back in once; anything beyond that is lost.
            folded = m_sum + sfcc_pkg::word_type'(m_carry);
            len = (m_count > 'hFFFF) ? sfcc_pkg::ALL_ONES : sfcc_pkg::word_type'(m_count);
            r = report_rsp(m_addr, m_ctrl, m_proto, ck, folded == sfcc_pkg::ALL_ONES,
                           m_count < sfcc_pkg::MIN_FRAME_BYTES, len);
            yields = 1'b1;
         end
         clear_frame_state();
      end else begin
         m_in_frame = 1'b1;
         if (m_count >= 2) begin
            oldest = m_hold[0];
            if (m_pend[8]) begin
               acc_word({m_pend[7:0], oldest});
               m_pend = '0;
            end else
               m_pend = {1'b1, oldest};
            if (m_count >= sfcc_pkg::MIN_FRAME_BYTES && !m_hold_drop[0]) begin
               r = data_rsp(oldest);
               yields = 1'b1;
            end
         end
         case (m_count)
            0: m_addr = b;
            1: m_ctrl = b;
            2: m_proto[15:8] = b;
            3: m_proto[7:0] = b;
            default: ;
         endcase
         m_hold[0] = m_hold[1];
         m_hold_drop[0] = m_hold_drop[1];
         m_hold[1] = b;
         m_hold_drop[1] = (b == sfcc_pkg::ESC_BYTE) && !esc_before;
         if (m_count != {COUNT_BITS{1'b1}})
            m_count++;
      end
      return yields;
   endfunction

   // Big-endian 16-bit ones' complement total, odd tail padded with a zero byte.
   function automatic sfcc_pkg::word_type ones_total(input sfcc_pkg::byte_type body[$]);
      logic [16:0]        s;
      sfcc_pkg::word_type w;
      s = '0;
      for (int i = 0; i < body.size(); i += 2) begin
         w = {body[i], (i + 1 < body.size()) ? body[i + 1] : 8'h00};
         s = {1'b0, s[15:0]} + {1'b0, w} + 17'(s[16]);
      end
      return s[15:0] + sfcc_pkg::word_type'(s[16]);
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endfunction

   task automatic push_byte(input sfcc_pkg::byte_type b, input bit typed = 1'b0,
                            input bit typed_yields = 1'b0,
                            input frame_rsp_type typed_rsp = NO_RSP);
      frame_rsp_type r;
      bit            yields;
      if (!tail_phase && !sender_calm && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      yields = deframe_byte(b, r);
      if (typed) begin
         yields = typed_yields;
         r = typed_rsp;
      end
      if (yields)
         expected_rsps.push_back(r);
      bytes_sent++;
      if (bytes_sent % 100 == 0)
         sender_calm = ($urandom_range(0, 3) == 0);
   endtask

   // Stimulus.
   initial begin
      stim_row_type       stim_rows [$];
      sfcc_pkg::byte_type body [$];
      sfcc_pkg::byte_type b;
      sfcc_pkg::byte_type prev;
      sfcc_pkg::word_type ck;
      int                 n_body;
      int                 n_noise;

      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      clear_frame_state();
      m_prev_esc = 1'b0;
      fail_count = 0;
      bytes_sent = 0;
      tail_phase = 1'b0;
      sender_calm = 1'b0;

      // Empty frame straight after reset, a one-byte frame, an all-ones header whose
      // checksum comes out good, an all-zero frame long enough to yield one data
      // transfer, then escapes that hide a flag and bytes that are dropped.
      stim_rows = '{
         '{sfcc_pkg::FLAG_BYTE, 1'b1, 1'b0, NO_RSP},
         '{8'hFF, 1'b1, 1'b0, NO_RSP},
         '{sfcc_pkg::FLAG_BYTE, 1'b1, 1'b1,
           report_rsp(8'hFF, 8'h00, 16'h0000, 16'h00FF, 1'b0, 1'b1, 16'd1)},
         '{8'hFF, 1'b1, 1'b0, NO_RSP},
         '{8'hFF, 1'b1, 1'b0, NO_RSP},
         '{8'hFF, 1'b1, 1'b0, NO_RSP},
         '{8'hFF, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b1, 1'b0, NO_RSP},
         '{sfcc_pkg::FLAG_BYTE, 1'b1, 1'b1,
           report_rsp(8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 16'd6)},
         '{8'h00, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b1, 1'b1, data_rsp(8'h00)},
         '{sfcc_pkg::FLAG_BYTE, 1'b1, 1'b1,
           report_rsp(8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'd7)},
         '{sfcc_pkg::ESC_BYTE, 1'b0, 1'b0, NO_RSP},
         '{sfcc_pkg::FLAG_BYTE, 1'b0, 1'b0, NO_RSP},
         '{sfcc_pkg::ESC_BYTE, 1'b0, 1'b0, NO_RSP},
         '{sfcc_pkg::ESC_BYTE, 1'b0, 1'b0, NO_RSP},
         '{8'h01, 1'b0, 1'b0, NO_RSP},
         '{sfcc_pkg::ESC_BYTE, 1'b0, 1'b0, NO_RSP},
         '{sfcc_pkg::FLAG_BYTE, 1'b0, 1'b0, NO_RSP},
         '{8'h80, 1'b0, 1'b0, NO_RSP},
         '{8'h81, 1'b0, 1'b0, NO_RSP},
         '{sfcc_pkg::FLAG_BYTE, 1'b0, 1'b0, NO_RSP}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i])
         push_byte(stim_rows[i].rx, stim_rows[i].typed, stim_rows[i].yields,
                   stim_rows[i].rsp);

      while (bytes_sent < RANDOM_BYTES) begin
         case ($urandom_range(0, 9))
            7: begin
               // Line noise with plenty of flags and escapes.
               n_noise = $urandom_range(1, 16);
               repeat (n_noise) begin
                  case ($urandom_range(0, 7))
                     0, 1: b = sfcc_pkg::FLAG_BYTE;
                     2: b = sfcc_pkg::ESC_BYTE;
                     default: b = sfcc_pkg::byte_type'($urandom_range(0, 255));
                  endcase
                  push_byte(b);
               end
            end
            8: begin
               // A frame whose closing flag is escaped, so it runs into the next one.
               repeat ($urandom_range(0, 8)) begin
                  b = sfcc_pkg::byte_type'($urandom_range(0, 255));
                  push_byte((b == sfcc_pkg::FLAG_BYTE) ? 8'h5A : b);
               end
               push_byte(sfcc_pkg::ESC_BYTE);
               push_byte(sfcc_pkg::FLAG_BYTE);
            end
            9: begin
               push_byte(sfcc_pkg::FLAG_BYTE);
               push_byte(sfcc_pkg::FLAG_BYTE);
            end
            default: begin
               body.delete();
               n_body = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3)
                                                    : $urandom_range(4, 38);
               while (body.size() < n_body) begin
                  case ($urandom_range(0, 9))
                     0: b = sfcc_pkg::ESC_BYTE;
                     1: b = sfcc_pkg::FLAG_BYTE;
                     default: b = sfcc_pkg::byte_type'($urandom_range(0, 255));
                  endcase
                  // A flag inside the frame must follow an escape.
                  if (b == sfcc_pkg::FLAG_BYTE &&
                      (body.size() == 0 || body[$] != sfcc_pkg::ESC_BYTE))
                     body.push_back(sfcc_pkg::ESC_BYTE);
                  body.push_back(b);
               end
               if ($urandom_range(0, 1) == 0)
                  ck = ~ones_total(body);
               else
                  ck = sfcc_pkg::word_type'($urandom_range(0, 65535));
               while ((ck[15:8] == sfcc_pkg::FLAG_BYTE &&
                       (body.size() == 0 || body[$] != sfcc_pkg::ESC_BYTE))
                      || ck[7:0] == sfcc_pkg::FLAG_BYTE || ck[7:0] == sfcc_pkg::ESC_BYTE)
                  ck = sfcc_pkg::word_type'($urandom_range(0, 65535));
               foreach (body[i])
                  push_byte(body[i]);
               push_byte(ck[15:8]);
               push_byte(ck[7:0]);
               push_byte(sfcc_pkg::FLAG_BYTE);
            end
         endcase
      end

      // One long frame, sent without gaps.
      tail_phase = 1'b1;
      push_byte(sfcc_pkg::FLAG_BYTE);
      prev = sfcc_pkg::FLAG_BYTE;
      repeat (LONG_FRAME) begin
         b = sfcc_pkg::byte_type'($urandom_range(0, 255));
         if (b == sfcc_pkg::FLAG_BYTE && prev != sfcc_pkg::ESC_BYTE)
            b = sfcc_pkg::ESC_BYTE;
         push_byte(b);
         prev = b;
      end
      if (prev == sfcc_pkg::ESC_BYTE)
         push_byte(8'h00);
      push_byte(sfcc_pkg::FLAG_BYTE);

      req_bus.valid <= 1'b0;
      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("** stuffed_frame_checksum_checker: PASSED **");
      else
         $display("** stuffed_frame_checksum_checker: FAILED **");
      $finish;
   end

   // Result side back-pressure, including one long hold-off that fills the block.
   initial begin
      int rsp_seen;
      int cycles;
      bit pressure_done;
      bit recv_calm;

      rsp_bus.ready = 1'b0;
      rsp_seen = 0;
      cycles = 0;
      pressure_done = 1'b0;
      recv_calm = 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            rsp_seen++;
         cycles++;
         if (cycles % 300 == 0)
            recv_calm = ($urandom_range(0, 3) == 0);
         if (!pressure_done && rsp_seen >= 60) begin
            pressure_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (!tail_phase && !recv_calm && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else
            rsp_bus.ready <= 1'b1;
      end
   end

   // Result checking and the watchdog.
   always @(posedge clock) begin
      frame_rsp_type got;
      frame_rsp_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.kind = rsp_bus.kind;
            got.data_byte = rsp_bus.data_byte;
            got.address = rsp_bus.address;
            got.control_field = rsp_bus.control_field;
            got.protocol = rsp_bus.protocol;
            got.checksum_word = rsp_bus.checksum_word;
            got.checksum_ok = rsp_bus.checksum_ok;
            got.too_short = rsp_bus.too_short;
            got.frame_bytes = rsp_bus.frame_bytes;
            if (expected_rsps.size() == 0) begin
               fail_count++;
               $error("result of kind %0d arrived with nothing expected", got.kind);
            end else begin
               want = expected_rsps.pop_front();
               compare_field("kind", want.kind, got.kind);
               compare_field("data_byte", want.data_byte, got.data_byte);
               compare_field("address", want.address, got.address);
               compare_field("control_field", want.control_field, got.control_field);
               compare_field("protocol", want.protocol, got.protocol);
               compare_field("checksum_word", want.checksum_word, got.checksum_word);
               compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
               compare_field("too_short", want.too_short, got.too_short);
               compare_field("frame_bytes", want.frame_bytes, got.frame_bytes);
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** stuffed_frame_checksum_checker: FAILED **");
            $finish;
         end
      end else
         quiet_cycles = 0;
   end

endmodule
